[rtl/pts_pkg.sv]
// pts_pkg: shared types and constants for the priority thread scheduler
// no dependencies

package pts_pkg;

	localparam int unsigned THREADS_DEF     = 8;
	localparam int unsigned SEMAPHORES_DEF  = 8;
	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam logic [7:0]  NEVER_PRIO      = 8'd255;

	typedef enum logic [2:0] {
		ACT_SLICE   = 3'd0,
		ACT_TICK    = 3'd1,
		ACT_SLEEP   = 3'd2,
		ACT_WAIT    = 3'd3,
		ACT_SIGNAL  = 3'd4,
		ACT_INIT    = 3'd5,
		ACT_UNUSED6 = 3'd6,
		ACT_UNUSED7 = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOELIG = 2'd1,
		ST_NOWAIT = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SEMRD,
		FSM_SCAN,
		FSM_TICK,
		FSM_DONE
	} fsm_t;

endpackage

[rtl/priority_thread_scheduler.sv]
// priority_thread_scheduler: top level, sequencer around thread and semaphore memories
// depends on pts_pkg, pts_thread_mem, pts_sem_mem
//
//  channel   | signals                                          | dir
//  request   | valid, ready, action, sleep_time, semaphore_index, init_value | in
//  result    | out_valid, out_ready, running_thread, caller_blocked,
//            | woken_thread, woke, semaphore_count, status      | out
//  config    | cfg_we, cfg_wdata                                | in
//
// one request at a time: for init and unused actions the sequencer passes FSM_SEMRD and
// FSM_DONE before out_valid rises; actions that walk the thread memory pass FSM_SCAN or
// FSM_TICK in between (one entry read per cycle, one write-back per cycle).
// after reset a clearing pass over the thread and semaphore memories runs first.
// a waiting result holds in its register; ready drops until it is taken and
// returns the cycle after.

module priority_thread_scheduler import pts_pkg::*; #(
	parameter int unsigned THREADS     = THREADS_DEF,
	parameter int unsigned SEMAPHORES  = SEMAPHORES_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [63:0]             cfg_wdata,
	input  logic                    valid,
	output logic                    ready,
	input  logic [2:0]              action,
	input  logic [31:0]             sleep_time,
	input  logic [2:0]              semaphore_index,
	input  logic signed [15:0]      init_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              running_thread,
	output logic                    caller_blocked,
	output logic [2:0]              woken_thread,
	output logic                    woke,
	output logic signed [15:0]      semaphore_count,
	output logic [1:0]              status
);

	localparam int unsigned TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int unsigned SW  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int unsigned CLR = (THREADS > SEMAPHORES) ? THREADS : SEMAPHORES;
	localparam int unsigned CW  = $clog2(CLR + 1);
	localparam int unsigned KW  = $clog2(THREADS + 2);
	localparam int unsigned SUMW = KW + 1;
	localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	fsm_t state_q, state_d;

	logic [63:0]   prio_q;
	logic [TW-1:0] cur_q;
	logic          clr_q;
	logic [CW-1:0] clr_cnt_q;

	// latched request
	logic [2:0]    act_q;
	logic [31:0]   stime_q;
	logic [SW-1:0] sem_q;
	logic signed [15:0] ival_q;

	// scan state
	logic [KW-1:0] k_q;          // entries issued
	logic [TW-1:0] rd_t_q;       // thread whose data is arriving
	logic          rd_v_q;
	logic [TW-1:0] best_t_q;
	logic [7:0]    best_p_q;
	logic          found_q;
	logic          woke_q;
	logic [TW-1:0] woken_q;
	logic          blk_q;
	logic [1:0]    st_q;
	logic signed [COUNT_WIDTH-1:0] cnt_q;
	logic          do_sched_q;
	logic          do_wake_q;

	// result register
	logic          ov_q;
	logic [2:0]    r_run_q;
	logic          r_cb_q;
	logic [2:0]    r_wt_q;
	logic          r_wk_q;
	logic [15:0]   r_cnt_q;
	logic [1:0]    r_st_q;

	// memory ports
	logic          tm_we;
	logic [TW-1:0] tm_waddr, tm_raddr;
	logic [31:0]   tm_wsleep, tm_rsleep;
	logic          tm_wblk, tm_rblk;
	logic [SW-1:0] tm_wsem, tm_rsem;
	logic          sm_we;
	logic [SW-1:0] sm_waddr, sm_raddr;
	logic signed [COUNT_WIDTH-1:0] sm_wdata, sm_rdata;

	pts_thread_mem #(.THREADS(THREADS), .SW(SW), .TW(TW)) u_tmem (
		.clk, .we(tm_we), .waddr(tm_waddr), .wsleep(tm_wsleep), .wblk(tm_wblk),
		.wsem(tm_wsem), .raddr(tm_raddr), .rsleep(tm_rsleep), .rblk(tm_rblk),
		.rsem(tm_rsem)
	);

	pts_sem_mem #(.SEMAPHORES(SEMAPHORES), .COUNT_WIDTH(COUNT_WIDTH), .SW(SW)) u_smem (
		.clk, .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata), .raddr(sm_raddr),
		.rdata(sm_rdata)
	);

	function automatic logic [7:0] prio_of(input logic [63:0] p, input logic [TW-1:0] t);
		logic [7:0] r;
		r = NEVER_PRIO;
		for (int i = 0; i < 8; i++) begin
			if (32'(t) == i) r = p[8*i +: 8];
		end
		return r;
	endfunction

	// index taken modulo the semaphore count, as a small table
	function automatic logic [SW-1:0] sem_wrap(input logic [2:0] idx);
		logic [SW-1:0] r;
		r = '0;
		for (int v = 0; v < 8; v++) begin
			if (32'(idx) == v) r = SW'(v % SEMAPHORES);
		end
		return r;
	endfunction

	logic [SW-1:0] sem_in;
	logic [TW-1:0] issue_t;
	logic [SUMW-1:0] isum;
	logic          scan_issue;
	logic [7:0]    rd_prio;
	logic          elig;
	logic signed [COUNT_WIDTH-1:0] ival_cl;
	logic          ival_sat;
	logic signed [31:0] ival_ext;
	logic signed [COUNT_WIDTH-1:0] cnt_n;
	logic [1:0]    st_n;
	logic          blk_n, sched_n, wake_n;

	assign sem_in = sem_wrap(semaphore_index);
	assign ready  = (state_q == FSM_IDLE) && !clr_q && !ov_q;
	assign rd_prio = prio_of(prio_q, rd_t_q);
	assign elig   = !tm_rblk && (tm_rsleep == '0);
	assign ival_ext = 32'(ival_q);

	always_comb begin
		ival_sat = 1'b0;
		ival_cl  = COUNT_WIDTH'(ival_ext);
		if (ival_ext > 32'(CMAX)) begin
			ival_cl = CMAX; ival_sat = 1'b1;
		end else if (ival_ext < 32'(CMIN)) begin
			ival_cl = CMIN; ival_sat = 1'b1;
		end
	end

	// decision on the semaphore read, taken in FSM_SEMRD
	always_comb begin
		cnt_n   = sm_rdata;
		st_n    = ST_OK;
		blk_n   = 1'b0;
		sched_n = 1'b0;
		wake_n  = 1'b0;
		case (act_q)
			ACT_SLICE, ACT_SLEEP: sched_n = 1'b1;
			ACT_WAIT: begin
				if (sm_rdata == CMIN) st_n = ST_SAT;
				else cnt_n = sm_rdata - 1'b1;
				// the caller blocks whenever the count was zero or below
				if (sm_rdata <= 0) begin
					blk_n = 1'b1; sched_n = 1'b1;
				end
			end
			ACT_SIGNAL: begin
				if (sm_rdata == CMAX) st_n = ST_SAT;
				else begin
					cnt_n = sm_rdata + 1'b1;
					if (sm_rdata < 0) wake_n = 1'b1;
				end
			end
			ACT_INIT: begin
				cnt_n = ival_cl;
				if (ival_sat) st_n = ST_SAT;
			end
			default: ;
		endcase
	end

	// entry issued this cycle during a walk: ring order after current
	always_comb begin
		isum = SUMW'(cur_q) + SUMW'(k_q) + 1'b1;
		if (isum >= SUMW'(THREADS)) isum = isum - SUMW'(THREADS);
		issue_t = scan_issue ? TW'(isum) : cur_q;
	end
	assign scan_issue = (k_q < KW'(THREADS));

	always_comb begin
		state_d  = state_q;
		tm_we    = 1'b0;
		tm_waddr = cur_q;
		tm_wsleep = tm_rsleep;
		tm_wblk  = tm_rblk;
		tm_wsem  = tm_rsem;
		tm_raddr = issue_t;
		sm_we    = 1'b0;
		sm_waddr = sem_q;
		sm_wdata = cnt_q;
		sm_raddr = sem_in;
		if (clr_q) begin
			tm_we = (clr_cnt_q < CW'(THREADS));
			tm_waddr = TW'(clr_cnt_q);
			tm_wsleep = '0; tm_wblk = 1'b0; tm_wsem = '0;
			sm_we = (clr_cnt_q < CW'(SEMAPHORES));
			sm_waddr = SW'(clr_cnt_q);
			sm_wdata = '0;
		end
		case (state_q)
			FSM_IDLE: begin
				// caller's entry is read at accept
				tm_raddr = cur_q;
				if (valid && ready) state_d = FSM_SEMRD;
			end
			FSM_SEMRD: begin
				// sleep and a blocking wait update the caller's entry now
				if (act_q == ACT_SLEEP) begin
					tm_we = 1'b1; tm_wsleep = stime_q;
				end
				if (blk_n) begin
					tm_we = 1'b1; tm_wblk = 1'b1; tm_wsem = sem_q;
				end
				if (act_q == ACT_INIT) begin
					sm_we = 1'b1; sm_wdata = ival_cl;
				end
				case (act_q)
					ACT_SLICE, ACT_SLEEP, ACT_WAIT, ACT_SIGNAL: state_d = FSM_SCAN;
					ACT_TICK: state_d = FSM_TICK;
					default: state_d = FSM_DONE;
				endcase
			end
			FSM_SCAN, FSM_TICK: begin
				if (rd_v_q) begin
					if (state_q == FSM_TICK && tm_rsleep != '0) begin
						tm_we = 1'b1; tm_waddr = rd_t_q;
						tm_wsleep = tm_rsleep - 1'b1;
					end
					if (state_q == FSM_SCAN && do_wake_q && !woke_q && tm_rblk
						&& tm_rsem == sem_q) begin
						tm_we = 1'b1; tm_waddr = rd_t_q;
						tm_wblk = 1'b0; tm_wsem = '0;
					end
				end
				if (!scan_issue && !rd_v_q) state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (act_q == ACT_WAIT || act_q == ACT_SIGNAL) sm_we = 1'b1;
				state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			prio_q    <= '0;
			cur_q     <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			ov_q      <= 1'b0;
			k_q       <= '0;
			rd_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) prio_q <= cfg_wdata;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CW'(CLR - 1)) clr_q <= 1'b0;
			end
			if (ov_q && out_ready) ov_q <= 1'b0;
			rd_v_q <= ((state_q == FSM_SCAN) || (state_q == FSM_TICK)) && scan_issue;
			case (state_q)
				FSM_IDLE: k_q <= '0;
				FSM_SEMRD: begin
					k_q <= '0;
				end
				FSM_SCAN, FSM_TICK: begin
					if (scan_issue) k_q <= k_q + 1'b1;
				end
				FSM_DONE: begin
					ov_q <= 1'b1;
					if (do_sched_q && found_q) cur_q <= best_t_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		rd_t_q <= issue_t;
		case (state_q)
			FSM_IDLE: begin
				act_q <= action; stime_q <= sleep_time;
				sem_q <= sem_in; ival_q <= init_value;
			end
			FSM_SEMRD: begin
				found_q <= 1'b0; best_p_q <= NEVER_PRIO; best_t_q <= cur_q;
				woke_q <= 1'b0; woken_q <= '0; blk_q <= blk_n; st_q <= st_n;
				cnt_q <= cnt_n; do_sched_q <= sched_n; do_wake_q <= wake_n;
			end
			FSM_SCAN: begin
				if (rd_v_q) begin
					if (do_sched_q && elig && rd_prio < best_p_q) begin
						best_p_q <= rd_prio; best_t_q <= rd_t_q; found_q <= 1'b1;
					end
					if (do_wake_q && !woke_q && tm_rblk && tm_rsem == sem_q) begin
						woke_q <= 1'b1; woken_q <= rd_t_q;
					end
				end
			end
			FSM_DONE: begin
				r_run_q <= 3'((do_sched_q && found_q) ? best_t_q : cur_q);
				r_cb_q  <= blk_q;
				r_wt_q  <= 3'(woken_q);
				r_wk_q  <= woke_q;
				r_cnt_q <= 16'(cnt_q);
				if (do_sched_q && !found_q) r_st_q <= ST_NOELIG;
				else if (do_wake_q && !woke_q) r_st_q <= ST_NOWAIT;
				else r_st_q <= st_q;
			end
			default: ;
		endcase
	end

	assign out_valid       = ov_q;
	assign running_thread  = r_run_q;
	assign caller_blocked  = r_cb_q;
	assign woken_thread    = r_wt_q;
	assign woke            = r_wk_q;
	assign semaphore_count = r_cnt_q;
	assign status          = r_st_q;

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |-> !ready) else $error("request taken while busy");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q) else $error("result dropped");
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !ready) else $error("request during clearing pass");

endmodule

[rtl/pts_thread_mem.sv]
// pts_thread_mem: per-thread state memory (sleep counter, blocked mark, semaphore)
// depends on pts_pkg

module pts_thread_mem import pts_pkg::*; #(
	parameter int unsigned THREADS = THREADS_DEF,
	parameter int unsigned SW      = 3,
	parameter int unsigned TW      = 3
) (
	input  logic              clk,
	input  logic              we,
	input  logic [TW-1:0]     waddr,
	input  logic [31:0]       wsleep,
	input  logic              wblk,
	input  logic [SW-1:0]     wsem,
	input  logic [TW-1:0]     raddr,
	output logic [31:0]       rsleep,
	output logic              rblk,
	output logic [SW-1:0]     rsem
);

	logic [32+SW:0] mem [THREADS];
	logic [32+SW:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wsleep, wblk, wsem};
		end
		rd_q <= mem[raddr];
	end

	assign rsleep = rd_q[32+SW:SW+1];
	assign rblk   = rd_q[SW];
	assign rsem   = rd_q[SW-1:0];

endmodule

[rtl/pts_sem_mem.sv]
// pts_sem_mem: semaphore count memory
// depends on pts_pkg

module pts_sem_mem import pts_pkg::*; #(
	parameter int unsigned SEMAPHORES  = SEMAPHORES_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int unsigned SW          = 3
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [SW-1:0]                 waddr,
	input  logic signed [COUNT_WIDTH-1:0] wdata,
	input  logic [SW-1:0]                 raddr,
	output logic signed [COUNT_WIDTH-1:0] rdata
);

	logic signed [COUNT_WIDTH-1:0] mem [SEMAPHORES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
